// ===== sv/tsvf_pkg.sv =====
// ----------------------------------------------------------------------------
// tsvf_pkg: shared types and constants of the text stream visualizing filter
// Register indexes, character codes, job descriptor and serializer sequence.
// ----------------------------------------------------------------------------
package tsvf_pkg;

    localparam int DIGITS_DEF  = 8;   // BCD digits of the line count, 6 to 10
    localparam int QDEPTH_DEF  = 2;   // entries of the job queue
    localparam int SIG_W       = 4;   // holds a digit count up to 10
    localparam int NUM_PAD     = 6;   // minimum width of a printed number
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

    // numbering modes
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_ALL      = 2'd1;
    localparam logic [1:0] MODE_NONBLANK = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CTRL_LIM = 8'h20;
    localparam logic [7:0] CTRL_FLIP = 8'h40;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } t_cfg;

    // what the serializer must print for one item, line number aside
    typedef struct packed {
        logic             num;     // print line number and tab
        logic             mpre;    // print "M-"
        logic             caret;   // print "^"
        logic             dollar;  // print "$"
        logic [SIG_W-1:0] sig;     // significant digits of the number
        logic [7:0]       ch;      // final character
    } t_job_ctl;

    // serializer sequence, one bit per output segment, low bit goes first
    typedef enum logic [6:0] {
        SQ_NUM    = 7'b0000001,
        SQ_TAB    = 7'b0000010,
        SQ_M      = 7'b0000100,
        SQ_DASH   = 7'b0001000,
        SQ_CARET  = 7'b0010000,
        SQ_DOLLAR = 7'b0100000,
        SQ_FINAL  = 7'b1000000
    } t_seq;

endpackage

// ===== sv/tsvf_front.sv =====
// ----------------------------------------------------------------------------
// tsvf_front: item classifier
// Tracks line context and BCD line count; unsqueezed bytes become jobs.
// ----------------------------------------------------------------------------
module tsvf_front import tsvf_pkg::*; #(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_new_file,
    input  logic                  i_full,
    output logic                  o_push,
    output logic [4*DIGITS-1:0]   o_count,
    output t_job_ctl              o_ctl
);

    localparam int CW = 4 * DIGITS;

    logic          r_prev_nl, n_prev_nl;
    logic          r_blank_seen, n_blank_seen;
    logic [CW-1:0] r_count, n_count;

    logic          w_accept, w_prev, w_blank, w_nl, w_drop, w_num;
    logic          w_all9, w_carry;
    logic [3:0]    w_d;
    logic [CW-1:0] w_inc;
    logic [7:0]    w_c;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    always_comb begin
        // a new file restarts line context before the byte is handled
        w_prev  = i_new_file ? 1'b1 : r_prev_nl;
        w_blank = i_new_file ? 1'b0 : r_blank_seen;
        w_nl    = (i_byte == CH_NL);
        w_drop  = i_cfg.squeeze_blank && w_nl && w_prev && w_blank;
        w_num   = w_prev && ((i_cfg.number_mode == MODE_ALL) ||
                             ((i_cfg.number_mode == MODE_NONBLANK) && !w_nl));

        // BCD increment, held once every digit is nine
        w_all9  = 1'b1;
        w_carry = 1'b1;
        w_inc   = r_count;
        o_ctl.sig = SIG_W'(1);
        for (int i = 0; i < DIGITS; i++) begin
            w_d = r_count[4*i +: 4];
            if (w_d != 4'd9) w_all9 = 1'b0;
            if (w_d != 4'd0) o_ctl.sig = SIG_W'(i + 1);
            if (w_carry) w_inc[4*i +: 4] = (w_d >= 4'd9) ? 4'd0 : w_d + 4'd1;
            w_carry = w_carry && (w_d >= 4'd9);
        end

        // character and its prefixes
        w_c         = i_byte;
        o_ctl.mpre  = 1'b0;
        o_ctl.caret = 1'b0;
        if (i_cfg.show_tabs && w_c == CH_TAB) begin
            o_ctl.caret = 1'b1;
            w_c         = CH_I;
        end
        if (i_cfg.show_nonprinting && w_c != CH_TAB && w_c != CH_NL) begin
            if (w_c[7]) begin
                o_ctl.mpre = 1'b1;
                w_c        = {1'b0, w_c[6:0]};
            end
            if (w_c < CTRL_LIM || w_c == CH_DEL) begin
                o_ctl.caret = 1'b1;
                w_c         = w_c ^ CTRL_FLIP;
            end
        end
        o_ctl.ch     = w_c;
        o_ctl.num    = w_num;
        o_ctl.dollar = i_cfg.show_ends && w_nl;

        n_prev_nl    = r_prev_nl;
        n_blank_seen = r_blank_seen;
        n_count      = r_count;
        if (w_accept && !w_drop) begin
            n_prev_nl    = w_nl;
            n_blank_seen = i_cfg.squeeze_blank && w_nl && w_prev;
            if (w_num && !w_all9) n_count = w_inc;
        end
    end

    assign o_push  = w_accept && !w_drop;
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_nl    <= 1'b1;
            r_blank_seen <= 1'b0;
            r_count      <= CW'(1);
        end else begin
            r_prev_nl    <= n_prev_nl;
            r_blank_seen <= n_blank_seen;
            r_count      <= n_count;
        end
    end

endmodule

// ===== sv/tsvf_fifo.sv =====
// ----------------------------------------------------------------------------
// tsvf_fifo: job queue
// Small first-in first-out buffer between classifier and serializer.
// ----------------------------------------------------------------------------
module tsvf_fifo import tsvf_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QDEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [NW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (w_pop)  r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            r_count <= r_count + NW'(w_push) - NW'(w_pop);
        end
    end

endmodule

// ===== sv/tsvf_back.sv =====
// ----------------------------------------------------------------------------
// tsvf_back: character serializer
// Expands one job into printed characters, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module tsvf_back import tsvf_pkg::*; #(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    input  logic [4*DIGITS-1:0] i_count,
    input  t_job_ctl            i_ctl,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_data,
    output logic                o_last
);

    localparam int CW = 4 * DIGITS;
    localparam int PW = $clog2(DIGITS);

    logic             r_busy;
    logic [6:0]       r_flags, n_flags;
    logic [PW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_count;
    logic [SIG_W-1:0] r_sig;
    logic [7:0]       r_char;
    logic             r_ov, r_ol;
    logic [7:0]       r_od;

    logic [6:0]       w_cur;
    logic             w_last, w_load_out, w_emit, w_take;
    logic [3:0]       w_dig;
    logic [7:0]       w_ch;
    logic [SIG_W-1:0] w_width;

    assign w_load_out = !r_ov || i_ready;
    assign w_emit     = r_busy && w_load_out;
    assign w_last     = (r_flags == SQ_FINAL);
    assign w_take     = i_job_valid && (!r_busy || (w_emit && w_last));
    assign o_job_pop  = w_take;
    assign w_width    = (i_ctl.sig > SIG_W'(NUM_PAD)) ? i_ctl.sig : SIG_W'(NUM_PAD);

    always_comb begin
        w_cur   = r_flags & (~r_flags + 7'd1);
        w_dig   = r_count[4*r_pos +: 4];
        if (w_dig > 4'd9) w_dig = 4'd9;
        n_flags = r_flags & ~w_cur;
        n_pos   = r_pos;
        case (t_seq'(w_cur))
            SQ_NUM: begin
                w_ch = (SIG_W'(r_pos) >= r_sig) ? CH_SPACE : CH_ZERO + {4'd0, w_dig};
                if (r_pos != '0) begin
                    n_flags = r_flags;
                    n_pos   = r_pos - 1'b1;
                end
            end
            SQ_TAB:    w_ch = CH_TAB;
            SQ_M:      w_ch = CH_M;
            SQ_DASH:   w_ch = CH_DASH;
            SQ_CARET:  w_ch = CH_CARET;
            SQ_DOLLAR: w_ch = CH_DOLL;
            SQ_FINAL:  w_ch = r_char;
            default:   w_ch = r_char;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_take) r_busy <= 1'b1;
            else if (w_emit && w_last) r_busy <= 1'b0;
            if (w_load_out) r_ov <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_flags <= {1'b1, i_ctl.dollar, i_ctl.caret, i_ctl.mpre, i_ctl.mpre,
                        i_ctl.num, i_ctl.num};
            r_pos   <= PW'(w_width - 1'b1);
            r_count <= i_count;
            r_sig   <= i_ctl.sig;
            r_char  <= i_ctl.ch;
        end else if (w_emit) begin
            r_flags <= n_flags;
            r_pos   <= n_pos;
        end
        if (w_emit) begin
            r_od <= w_ch;
            r_ol <= w_last;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_last  = r_ol;

endmodule

// ===== sv/text_stream_visualize_filter.sv =====
// ----------------------------------------------------------------------------
// text_stream_visualize_filter: cat-style text visualizing filter
// Squeezes blank lines, numbers lines, and shows tabs, ends and control bytes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: byte, tuser: new file
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: char, tlast: last of item
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  The classifier takes one byte per cycle while the job queue has room.
//  The serializer prints one character per cycle unless the output stalls, and
//  takes the next job with the final character of the current one. An item prints
//  1 plain character, up to 4 with prefixes, plus max(6, digits) + 1 with numbering.
//  Reset (synchronous, active low) empties queue and output and sets the
//  line count to 1; the output register holds its beat while m_axis_tready
//  is low, and the classifier keeps going until the queue fills.
// ----------------------------------------------------------------------------
module text_stream_visualize_filter import tsvf_pkg::*; #(
    parameter int DIGITS = DIGITS_DEF,
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input text stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
    input  logic                  s_axis_tuser,   // [0] new_file
    // output character stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
    output logic                  m_axis_tlast
);

    localparam int CW = 4 * DIGITS;
    localparam int JW = CW + $bits(t_job_ctl);

    t_cfg          r_cfg;
    logic          w_push, w_full, w_pop, w_qvalid;
    logic [CW-1:0] w_count, w_qcount;
    t_job_ctl      w_ctl, w_qctl;
    logic [JW-1:0] w_qdata;

    // Configuration is taken in any cycle; the write lands in one register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NUMBER_MODE:      r_cfg.number_mode      <= i_cfg_data[1:0];
                REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data[0];
                REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data[0];
                REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data[0];
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Front: classify each byte, advance line context and count.
    tsvf_front #(.DIGITS(DIGITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_new_file (s_axis_tuser),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_count    (w_count),
        .o_ctl      (w_ctl)
    );

    // Queue: a job carries a snapshot of the count taken before its bump.
    tsvf_fifo #(.WIDTH(JW), .DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_count, w_ctl}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qdata)
    );

    assign w_qcount = w_qdata[JW-1 -: CW];
    assign w_qctl   = t_job_ctl'(w_qdata[$bits(t_job_ctl)-1:0]);

    // Back: print each job one beat at a time.
    tsvf_back #(.DIGITS(DIGITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qvalid),
        .o_job_pop   (w_pop),
        .i_count     (w_qcount),
        .i_ctl       (w_qctl),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

// ===== sv/tsvf_checker.sv =====
// ----------------------------------------------------------------------------
// tsvf_checker: port-level checks of the visualizing filter
// Watches the streams after reset and the placement of line-end beats.
// ----------------------------------------------------------------------------
module tsvf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // reset empties the job queue, so the input side is ready
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // a newline is only ever printed as the final character of an item
    a_nl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata == 8'h0A) |-> m_axis_tlast)
        else $error("newline beat without tlast");

endmodule

bind text_stream_visualize_filter tsvf_checker u_tsvf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/text_stream_visualize_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_stream_visualize_filter_tb: self-checking bench of the cat-style filter
// Drives text bytes in bursts, renders each accepted byte in a local model of
// the filter, and checks every output character and its tlast flag in order.
// ----------------------------------------------------------------------------
module text_stream_visualize_filter_tb;
    import tsvf_pkg::*;

    localparam int          DIGITS     = DIGITS_DEF;
    localparam int          HALF_CLK   = 2;
    localparam int          SETTLE_CYC = 40;         // queue plus longest item
    localparam int          LIMIT_NS   = 1_000_000;
    localparam logic [1:0]  MODE_UNDEF = 2'd3;       // numbers nothing, like none
    localparam int          RAND_PHASES = 5;
    localparam int          PHASE_ITEMS = 50;

    typedef struct {
        logic [7:0] ch;
        logic       is_last;
    } t_char_beat;

    // DUT ports; every input starts at a known value
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] in_byte
    logic                  s_axis_tuser  = 1'b0; // [0] new_file
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [7:0] out_byte
    logic                  m_axis_tlast;         // [0] last

    // local copy of the filter: registers and line context
    t_cfg                  cfg_copy      = '0;
    logic                  at_line_start = 1'b1;
    logic                  blank_printed = 1'b0;
    logic [4*DIGITS-1:0]   line_no_bcd   = 1;

    t_char_beat            rendered_chars[$];
    int                    mismatch_count = 0;
    int                    burst_left     = 0;

    text_stream_visualize_filter #(
        .DIGITS (DIGITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(HALF_CLK) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Line number: print right justified in at least six columns plus a tab,
    // then advance the BCD count unless every digit is already nine.
    // ------------------------------------------------------------------------
    function automatic void push_line_number(ref logic [7:0] chars[$]);
        int sig;
        sig = 1;
        for (int i = 0; i < DIGITS; i++)
            if (line_no_bcd[4*i +: 4] != 4'd0) sig = i + 1;
        // wide numbers get no padding at all
        for (int i = sig; i < NUM_PAD; i++) chars.push_back(CH_SPACE);
        for (int i = sig - 1; i >= 0; i--)
            chars.push_back(CH_ZERO + {4'd0, line_no_bcd[4*i +: 4]});
        chars.push_back(CH_TAB);
    endfunction

    function automatic void advance_line_number();
        logic all_nine;
        all_nine = 1'b1;
        for (int i = 0; i < DIGITS; i++)
            if (line_no_bcd[4*i +: 4] != 4'd9) all_nine = 1'b0;
        if (all_nine) return;   // saturated: hold the count
        for (int i = 0; i < DIGITS; i++) begin
            if (line_no_bcd[4*i +: 4] == 4'd9) begin
                line_no_bcd[4*i +: 4] = 4'd0;   // carry into the next digit
            end else begin
                line_no_bcd[4*i +: 4] = line_no_bcd[4*i +: 4] + 4'd1;
                break;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Render one accepted byte into the characters the filter prints for it
    // and queue them; the final one carries tlast.
    // ------------------------------------------------------------------------
    function automatic void render_byte(input logic [7:0] in_byte, input logic new_file);
        logic [7:0] c;
        logic       is_nl;
        logic [7:0] chars[$];
        c     = in_byte;
        is_nl = (in_byte == CH_NL);
        // a new file restarts the line context, the count goes on
        if (new_file) begin
            at_line_start = 1'b1;
            blank_printed = 1'b0;
        end
        if (cfg_copy.squeeze_blank && is_nl && at_line_start) begin
            if (blank_printed) return;   // drop a repeated blank line whole
            blank_printed = 1'b1;
        end else begin
            blank_printed = 1'b0;
        end
        if (at_line_start && (cfg_copy.number_mode == MODE_ALL ||
                (cfg_copy.number_mode == MODE_NONBLANK && !is_nl))) begin
            push_line_number(chars);
            advance_line_number();
        end
        if (cfg_copy.show_tabs && c == CH_TAB) begin
            chars.push_back(CH_CARET);
            c = CH_I;
        end
        if (cfg_copy.show_nonprinting && c != CH_TAB && c != CH_NL) begin
            if (c[7]) begin
                c[7] = 1'b0;
                chars.push_back(CH_M);
                chars.push_back(CH_DASH);
            end
            if (c < CTRL_LIM || c == CH_DEL) begin
                c = c ^ CTRL_FLIP;
                chars.push_back(CH_CARET);
            end
        end
        if (cfg_copy.show_ends && is_nl) chars.push_back(CH_DOLL);
        chars.push_back(c);
        at_line_start = is_nl;
        foreach (chars[i])
            rendered_chars.push_back('{ch: chars[i], is_last: (i == chars.size() - 1)});
    endfunction

    // ------------------------------------------------------------------------
    // Send one byte beat. Start a new burst with a random gap when the current
    // one runs out; keep tvalid high between beats of a burst.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] in_byte, input logic new_file);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= in_byte;
        s_axis_tuser  <= new_file;
        do @(posedge i_clk); while (!s_axis_tready);
        render_byte(in_byte, new_file);
        @(negedge i_clk);
    endtask

    // Drop tvalid, wait for every queued character, then let a possibly
    // squeezed last byte clear the pipeline before touching registers.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (rendered_chars.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Write all five registers back to back; random filler in unused bits.
    task automatic configure(input logic [1:0] mode, input logic squeeze,
                             input logic ends, input logic tabs, input logic nonprint);
        logic [CFG_IDX_W-1:0]  idxs[5];
        logic [CFG_DATA_W-1:0] vals[5];
        logic [CFG_DATA_W-1:0] filler;
        settle();
        idxs = '{REG_NUMBER_MODE, REG_SQUEEZE_BLANK, REG_SHOW_ENDS,
                 REG_SHOW_TABS, REG_SHOW_NONPRINTING};
        filler = $urandom; vals[0] = (filler << 2) | mode;
        filler = $urandom; vals[1] = (filler << 1) | squeeze;
        filler = $urandom; vals[2] = (filler << 1) | ends;
        filler = $urandom; vals[3] = (filler << 1) | tabs;
        filler = $urandom; vals[4] = (filler << 1) | nonprint;
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idxs[i])
                REG_NUMBER_MODE:      cfg_copy.number_mode      = vals[i][1:0];
                REG_SQUEEZE_BLANK:    cfg_copy.squeeze_blank    = vals[i][0];
                REG_SHOW_ENDS:        cfg_copy.show_ends        = vals[i][0];
                REG_SHOW_TABS:        cfg_copy.show_tabs        = vals[i][0];
                REG_SHOW_NONPRINTING: cfg_copy.show_nonprinting = vals[i][0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly readable text, with newlines, tabs, controls and high bytes.
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 8'($urandom_range(8'h20, 8'h7E));
        if (pick < 70) return CH_TAB;
        if (pick < 82) return 8'($urandom_range(8'h00, 8'h1F));
        if (pick < 85) return CH_DEL;
        return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults: every byte passes through unchanged.
    task automatic test_plain_passthrough();
        send_byte(8'h41, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NL, 1'b0);
    endtask

    // All options on: numbered lines, squeezed blank runs, a new file in the
    // middle of a blank run, and every notation prefix.
    task automatic test_full_markup();
        configure(MODE_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);    // squeezed, count holds
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b1);    // new file lets one blank line through again
        send_byte(8'h78, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h89, 1'b0);    // M-^I
        send_byte(8'h9F, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(CH_NL, 1'b0);
    endtask

    // Non-blank numbering skips empty lines; squeeze off keeps all of them.
    task automatic test_nonblank_numbering();
        configure(MODE_NONBLANK, 1'b0, 1'b0, 1'b0, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(CH_NL, 1'b0);
    endtask

    // Mode three numbers nothing.
    task automatic test_undefined_mode();
        configure(MODE_UNDEF, 1'b0, 1'b1, 1'b0, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(CH_NL, 1'b0);
    endtask

    // Random lines of random length under several register settings; blank
    // runs and new-file marks show up regularly.
    task automatic test_random_text();
        int         sent;
        int         line_len;
        logic       file_start;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0:       configure(MODE_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1);
                1:       configure(MODE_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
                default: configure(2'($urandom_range(0, 3)), 1'($urandom),
                                   1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // blank lines a third of the time, so squeeze sees real runs
                line_len   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                file_start = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < line_len; k++) begin
                    send_byte(text_byte(), file_start && k == 0);
                    sent++;
                end
                send_byte(CH_NL, file_start && line_len == 0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready pattern switches between always ready, coin flip, mostly
    // stalled and a fixed duty cycle, each style held for a random stretch.
    // ------------------------------------------------------------------------
    int ready_style      = 0;
    int ready_style_left = 0;
    int ready_tick       = 0;

    always @(negedge i_clk) begin
        if (ready_style_left == 0) begin
            ready_style      = $urandom_range(0, 3);
            ready_style_left = $urandom_range(16, 64);
        end
        ready_style_left--;
        ready_tick++;
        case (ready_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (ready_tick % 5 != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Output check: every beat against the oldest rendered character.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_beat exp_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rendered_chars.size() == 0) begin
                $error("unexpected beat: out_byte %h last %b", m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                exp_beat = rendered_chars.pop_front();
                if (m_axis_tdata !== exp_beat.ch) begin
                    $error("out_byte mismatch: expected %h actual %h",
                           exp_beat.ch, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== exp_beat.is_last) begin
                    $error("last mismatch: expected %b actual %b",
                           exp_beat.is_last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed tests, random text, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_plain_passthrough();
        test_full_markup();
        test_nonblank_numbering();
        test_undefined_mode();
        test_random_text();

        s_axis_tvalid <= 1'b0;
        while (rendered_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        // leftovers here mean characters that never arrived
        if (mismatch_count == 0 && rendered_chars.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
